// ----- hdl/diagonal_difference_edge_marker_core_defines.svh -----
// Assertion macros used by the checker file of the edge marker.
`ifndef DIAGONAL_DIFFERENCE_EDGE_MARKER_CORE_DEFINES_SVH
`define DIAGONAL_DIFFERENCE_EDGE_MARKER_CORE_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define DDEM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define DDEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ddem_pkg.sv -----
// Types and constants of the diagonal difference edge marker.
`timescale 1ns / 1ps
`default_nettype none

package ddem_pkg;

  localparam int unsigned CFG_WIDTH_W = 12;
  localparam int unsigned THRESH_W    = 10;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned RGB_W       = 24;
  localparam int unsigned SUM_W       = 10;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_EDGE_THRESHOLD = 2'd1,
    CFG_EDGE_INTENSITY = 2'd2,
    CFG_BACKGROUND_RGB = 2'd3
  } cfg_index_e;

  localparam logic [CFG_WIDTH_W-1:0] RESET_IMAGE_WIDTH    = 12'd640;
  localparam logic [THRESH_W-1:0]    RESET_EDGE_THRESHOLD = 10'd100;
  localparam logic [CHAN_W-1:0]      RESET_EDGE_INTENSITY = 8'd192;
  localparam logic [RGB_W-1:0]       RESET_BACKGROUND_RGB = 24'hFFFFFF;

  // Red component of every edge pixel.
  localparam logic [CHAN_W-1:0] EDGE_RED = 8'd0;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

endpackage

`default_nettype wire

// ----- hdl/diagonal_difference_edge_marker_core.sv -----
// Diagonal difference edge marker: line store, difference sum and output stage.
//
// Pixels enter in raster order on the input channel (in_valid_i / in_stall_o),
// with frame_start_i marking the first pixel of an image. Each accepted item
// yields exactly one output item (out_valid_o / out_stall_i): the edge colour
// when the summed RGB difference to the upper-left pixel exceeds the threshold,
// else the background colour. Row 0 and column 0 always get the background.
// An accepted item is registered in the difference stage and then in the output
// register. Throughput is one item per clock while the receiver does not stall;
// the line store is a single memory read and written at the same slot in the
// accept cycle, and the read data is registered before the difference sum.
// When the receiver stalls, the output item holds and one more item can sit in
// the difference stage; after that in_stall_o follows out_stall_i.
// Configuration is written through cfg_valid_i / cfg_ready_o; the user must do so
// only while the block is idle, which the block itself does not enforce; cfg_ready_o is always high.
// Reset clears position, row and pointer state and loads the register reset
// values. The line store is not cleared: stale slots feed only unchecked pixels.
`timescale 1ns / 1ps
`default_nettype none

module diagonal_difference_edge_marker_core
  import ddem_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write channel
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [RGB_W-1:0]       cfg_data_i,
  // pixel input channel
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [CHAN_W-1:0]      pix_red_i,
  input  wire logic [CHAN_W-1:0]      pix_green_i,
  input  wire logic [CHAN_W-1:0]      pix_blue_i,
  input  wire logic                   frame_start_i,
  // pixel output channel
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [CHAN_W-1:0]           out_red_o,
  output logic [CHAN_W-1:0]           out_green_o,
  output logic [CHAN_W-1:0]           out_blue_o,
  output logic                        is_edge_o
);

  localparam int unsigned DEPTH = MAX_WIDTH + 1;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned XW    = (PW > CFG_WIDTH_W) ? PW : CFG_WIDTH_W;

  // configuration registers
  logic [CFG_WIDTH_W-1:0] width_q;
  logic [THRESH_W-1:0]    thresh_q;
  logic [CHAN_W-1:0]      intensity_q;
  logic [RGB_W-1:0]       bg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= RESET_IMAGE_WIDTH;
      thresh_q    <= RESET_EDGE_THRESHOLD;
      intensity_q <= RESET_EDGE_INTENSITY;
      bg_q        <= RESET_BACKGROUND_RGB;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:    width_q     <= cfg_data_i[CFG_WIDTH_W-1:0];
        CFG_EDGE_THRESHOLD: thresh_q    <= cfg_data_i[THRESH_W-1:0];
        CFG_EDGE_INTENSITY: intensity_q <= cfg_data_i[CHAN_W-1:0];
        CFG_BACKGROUND_RGB: bg_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Width clamped into 1 .. MAX_WIDTH.
  logic [XW-1:0] width_ext;
  logic [PW-1:0] eff_w;

  assign width_ext = XW'(width_q);

  always_comb begin
    if (width_q == '0) begin
      eff_w = PW'(1);
    end else if (width_ext > XW'(MAX_WIDTH)) begin
      eff_w = PW'(MAX_WIDTH);
    end else begin
      eff_w = width_ext[PW-1:0];
    end
  end

  // handshake and pipeline control
  logic s1_valid_q;
  logic out_valid_q;
  logic out_ready;
  logic s1_adv;
  logic in_accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // position state
  logic [CW-1:0] col_q;
  logic          pfr_q;
  logic [PW-1:0] ptr_q;

  logic [CW-1:0] col_cur;
  logic          pfr_cur;
  logic [PW-1:0] ptr_raw;
  logic [PW-1:0] ptr_cur;
  logic [PW:0]   col_ext;
  logic [PW:0]   w_ext;
  logic          check_en;
  logic          col_last;
  pixel_t        pix_in;

  assign pix_in = '{red: pix_red_i, green: pix_green_i, blue: pix_blue_i};

  always_comb begin
    if (frame_start_i) begin
      col_cur = '0;
      pfr_cur = 1'b0;
      ptr_raw = '0;
    end else begin
      col_cur = col_q;
      pfr_cur = pfr_q;
      ptr_raw = ptr_q;
    end
    // A pointer beyond a shrunken ring wraps to the first slot.
    ptr_cur  = (ptr_raw > eff_w) ? '0 : ptr_raw;
    col_ext  = (PW + 1)'(col_cur);
    w_ext    = {1'b0, eff_w};
    check_en = pfr_cur && (col_cur != '0) && (col_ext < w_ext);
    col_last = (col_ext + (PW + 1)'(1)) >= w_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      pfr_q <= 1'b0;
      ptr_q <= '0;
    end else if (in_accept) begin
      col_q <= col_last ? '0 : col_cur + CW'(1);
      pfr_q <= col_last ? 1'b1 : pfr_cur;
      ptr_q <= (ptr_cur >= eff_w) ? '0 : ptr_cur + PW'(1);
    end
  end

  // Line store: the slot is read and overwritten in the same cycle, so the
  // read returns the pixel from one ring length earlier.
  logic [RGB_W-1:0] line_mem [DEPTH];
  pixel_t           prev_q;
  pixel_t           cur_q;
  logic             check_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      prev_q            <= line_mem[ptr_cur];
      line_mem[ptr_cur] <= pix_in;
      cur_q             <= pix_in;
      check_q           <= check_en;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // difference sum stage
  logic [CHAN_W-1:0] diff_r;
  logic [CHAN_W-1:0] diff_g;
  logic [CHAN_W-1:0] diff_b;
  logic [SUM_W-1:0]  sum;
  logic              edge_hit;

  always_comb begin
    diff_r = (cur_q.red > prev_q.red) ? cur_q.red - prev_q.red : prev_q.red - cur_q.red;
    diff_g = (cur_q.green > prev_q.green) ? cur_q.green - prev_q.green
                                          : prev_q.green - cur_q.green;
    diff_b = (cur_q.blue > prev_q.blue) ? cur_q.blue - prev_q.blue
                                        : prev_q.blue - cur_q.blue;
    sum      = SUM_W'(diff_r) + SUM_W'(diff_g) + SUM_W'(diff_b);
    edge_hit = check_q && (sum > thresh_q);
  end

  // output register
  pixel_t out_pix_q;
  logic   is_edge_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (edge_hit) begin
        out_pix_q <= '{red: EDGE_RED, green: intensity_q >> 1, blue: intensity_q};
      end else begin
        out_pix_q <= bg_q;
      end
      is_edge_q <= edge_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_pix_q.red;
  assign out_green_o = out_pix_q.green;
  assign out_blue_o  = out_pix_q.blue;
  assign is_edge_o   = is_edge_q;

endmodule

`default_nettype wire

// ----- hdl/ddem_checker.sv -----
// Port-level checks of the edge marker, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "diagonal_difference_edge_marker_core_defines.svh"

module ddem_checker
  import ddem_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [CHAN_W-1:0]    out_red_o,
  input wire logic [CHAN_W-1:0]    out_green_o,
  input wire logic [CHAN_W-1:0]    out_blue_o,
  input wire logic                 is_edge_o
);

  // A stalled output item stays in place with all its fields.
  `DDEM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_red_o) && $stable(out_green_o)
      && $stable(out_blue_o) && $stable(is_edge_o),
    "stalled output item changed")

  // The input only backs up when the output is full and blocked.
  `DDEM_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o,
    out_valid_o && out_stall_i, "input stalled without a blocked output")

  // An edge pixel carries the edge colour: no red, green half of blue.
  `DDEM_ASSERT_NOW(a_edge_colour, clk_i, rst_ni, out_valid_o && is_edge_o,
    (out_red_o == EDGE_RED) && (out_green_o == (out_blue_o >> 1)), "edge colour malformed")

  // If an item enters behind a blocked output, a held stall stops input.
  `DDEM_ASSERT_NEXT(a_backpressure, clk_i, rst_ni,
    in_valid_i && !in_stall_o && out_valid_o && out_stall_i,
    !out_stall_i || in_stall_o, "input not stalled with a full pipeline")

endmodule

bind diagonal_difference_edge_marker_core ddem_checker u_ddem_checker (.*);

`default_nettype wire
